// ----- design/fequ_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fequ_pkg
// Shared constants and types of the field energy quadrature accumulator.
// ----------------------------------------------------------------------------
package fequ_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);

  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);

  localparam logic [15:0] GAUSS_A0   = 16'd13849;
  localparam logic [15:0] GAUSS_A1   = 16'd51687;
  localparam logic [17:0] PI_Q16     = 18'd205887;
  localparam logic [62:0] ENERGY_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CELL = 1'b1;

  localparam logic CFG_GEOMETRY = 1'b0;
  localparam logic CFG_WEIGHT   = 1'b1;

  typedef struct packed {
    logic [15:0]        beta;
    logic signed [15:0] ex_near;
    logic signed [15:0] ex_far;
    logic signed [15:0] ey_near;
    logic signed [15:0] ey_far;
    logic [15:0]        cell_width;
    logic [15:0]        cell_height;
    logic signed [15:0] radius_start;
    logic               last;
    logic [15:0]        er0;
    logic [15:0]        eri;
  } cell_t;

  typedef struct packed {
    logic           empty;
    logic [FQ_AW:0] level;
  } fq_stat_t;

endpackage

// ----- design/fequ_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fequ_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module fequ_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/fequ_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fequ_fifo
// Short queue of classified cell items between front and back end.
// ----------------------------------------------------------------------------
module fequ_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  fequ_pkg::cell_t   data_i,
  input  logic              pop_i,
  output fequ_pkg::cell_t   data_o,
  output fequ_pkg::fq_stat_t stat_o
);

  fequ_pkg::cell_t mem_r [fequ_pkg::FQ_DEPTH];
  logic [fequ_pkg::FQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [fequ_pkg::FQ_AW:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push_i) begin
      wp_nxt = wp_r + 1'b1;
    end
    if (pop_i) begin
      rp_nxt = rp_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wp_r] <= data_i;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign data_o       = mem_r[rp_r];
  assign stat_o.empty = (cnt_r == '0);
  assign stat_o.level = cnt_r;

endmodule

// ----- design/fequ_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fequ_front
// Accepts items, services table loads and looks up permittivity for cells.
// ----------------------------------------------------------------------------
module fequ_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_command,
  input  logic [15:0]        in_table_value,
  input  logic [7:0]         in_er_index,
  input  logic [15:0]        in_beta,
  input  logic signed [15:0] in_ex_near,
  input  logic signed [15:0] in_ex_far,
  input  logic signed [15:0] in_ey_near,
  input  logic signed [15:0] in_ey_far,
  input  logic [15:0]        in_cell_width,
  input  logic [15:0]        in_cell_height,
  input  logic signed [15:0] in_radius_start,
  input  logic               in_last,
  input  fequ_pkg::fq_stat_t fq_stat,
  output logic               fq_push,
  output fequ_pkg::cell_t    fq_data
);

  logic                          accept;
  logic                          in_range;
  logic [fequ_pkg::TBL_AW-1:0]   tbl_addr;
  logic [15:0]                   tbl_rdata;
  logic [fequ_pkg::FQ_AW+1:0]    fill;
  logic                          s1_v_r, s1_v_nxt;
  logic                          s1_range_r;
  fequ_pkg::cell_t               s1_r;
  logic [15:0]                   er0_r;

  assign fill     = (fequ_pkg::FQ_AW+2)'(fq_stat.level) + (fequ_pkg::FQ_AW+2)'(s1_v_r);
  assign in_full  = (fill >= (fequ_pkg::FQ_AW+2)'(fequ_pkg::FQ_DEPTH));
  assign accept   = in_push && !in_full;
  assign in_range = (32'(in_er_index) < fequ_pkg::TABLE_DEPTH);
  assign tbl_addr = fequ_pkg::TBL_AW'(in_er_index);
  assign s1_v_nxt = accept && (in_command == fequ_pkg::CMD_CELL);

  fequ_ram #(
    .WIDTH(16),
    .DEPTH(fequ_pkg::TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (accept && (in_command == fequ_pkg::CMD_LOAD) && in_range),
    .waddr(tbl_addr),
    .wdata(in_table_value),
    .re   (s1_v_nxt),
    .raddr(tbl_addr),
    .rdata(tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept && (in_command == fequ_pkg::CMD_LOAD) && (in_er_index == 8'd0)) begin
      er0_r <= in_table_value;
    end
    if (s1_v_nxt) begin
      s1_range_r          <= in_range;
      s1_r.beta           <= in_beta;
      s1_r.ex_near        <= in_ex_near;
      s1_r.ex_far         <= in_ex_far;
      s1_r.ey_near        <= in_ey_near;
      s1_r.ey_far         <= in_ey_far;
      s1_r.cell_width     <= in_cell_width;
      s1_r.cell_height    <= in_cell_height;
      s1_r.radius_start   <= in_radius_start;
      s1_r.last           <= in_last;
      s1_r.er0            <= er0_r;
      s1_r.eri            <= '0;
    end
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_comb begin
    fq_data     = s1_r;
    fq_data.eri = s1_range_r ? tbl_rdata : 16'd0;
  end

  assign fq_push = s1_v_r;

endmodule

// ----- design/fequ_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fequ_back
// Quadrature sequencer on one shared multiplier, accumulator and result.
// ----------------------------------------------------------------------------
module fequ_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               geometry_mode,
  input  logic               weight_by_permittivity,
  input  fequ_pkg::fq_stat_t fq_stat,
  input  fequ_pkg::cell_t    fq_data,
  output logic               fq_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [62:0]        out_energy,
  output logic               out_saturated
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_EX0, ST_EX1, ST_EY0, ST_EY1, ST_R0, ST_R1,
    ST_SQX0, ST_SQX1, ST_SQY0, ST_SQY1, ST_SUM, ST_T0, ST_T1,
    ST_ER0, ST_ER1, ST_ER2, ST_MLO, ST_MHI, ST_MTOP, ST_MRND, ST_ACC
  } state_t;

  typedef enum logic [1:0] {MOP_PI, MOP_W, MOP_H, MOP_ER} mop_t;

  state_t state_r, state_nxt;
  mop_t   mop_r, mop_nxt;
  fequ_pkg::cell_t cell_r, cell_nxt;
  logic [16:0] mx0_r, mx0_nxt, mx1_r, mx1_nxt, my0_r, my0_nxt, my1_r, my1_nxt;
  logic [16:0] mr0_r, mr0_nxt, mr1_r, mr1_nxt;
  logic [30:0] qx0_r, qx0_nxt, qx1_r, qx1_nxt, qy0_r, qy0_nxt, qy1_r, qy1_nxt;
  logic [63:0] x_r, x_nxt;
  logic [3:0]  xt_r, xt_nxt;
  logic [17:0] b_r, b_nxt;
  logic [83:0] acc_r, acc_nxt;
  logic [31:0] n_r, n_nxt;
  logic        clip_r, clip_nxt;
  logic [62:0] energy_r, energy_nxt;
  logic        ovf_r, ovf_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [62:0] oen_r, oen_nxt;
  logic        osat_r, osat_nxt;

  logic signed [33:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [52:0] prod;
  logic signed [15:0] iv0;
  logic signed [16:0] id;
  logic [15:0]        ga;
  logic [35:0]        lval, lmag, lsum;
  logic [16:0]        mval;
  logic [32:0]        fsum;
  logic [32:0]        nq;
  logic [83:0]        rsum, rshift;
  logic [63:0]        esum;
  logic               out_free;

  assign prod = mul_a * mul_b;

  // interpolation source per step
  always_comb begin
    iv0 = cell_r.ex_near;
    id  = 17'(cell_r.ex_far) - 17'(cell_r.ex_near);
    ga  = fequ_pkg::GAUSS_A0;
    case (state_r)
      ST_EX1: begin
        ga = fequ_pkg::GAUSS_A1;
      end
      ST_EY0, ST_EY1: begin
        iv0 = cell_r.ey_near;
        id  = 17'(cell_r.ey_far) - 17'(cell_r.ey_near);
        ga  = (state_r == ST_EY1) ? fequ_pkg::GAUSS_A1 : fequ_pkg::GAUSS_A0;
      end
      ST_R0, ST_R1: begin
        iv0 = cell_r.radius_start;
        id  = signed'({1'b0, cell_r.cell_width});
        ga  = (state_r == ST_R1) ? fequ_pkg::GAUSS_A1 : fequ_pkg::GAUSS_A0;
      end
      default: begin
      end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = 34'(id);
    mul_b = signed'({3'b0, ga});
    fsum  = 33'(qx0_r) + 33'(qx1_r) + {1'b0, qy0_r, 1'b0};
    case (state_r)
      ST_SQX0: begin
        mul_a = signed'({17'b0, mx0_r});
        mul_b = signed'({2'b0, mx0_r});
      end
      ST_SQX1: begin
        mul_a = signed'({17'b0, mx1_r});
        mul_b = signed'({2'b0, mx1_r});
      end
      ST_SQY0: begin
        mul_a = signed'({17'b0, my0_r});
        mul_b = signed'({2'b0, my0_r});
      end
      ST_SQY1: begin
        mul_a = signed'({17'b0, my1_r});
        mul_b = signed'({2'b0, my1_r});
      end
      ST_T0: begin
        mul_a = signed'({1'b0, fsum});
        mul_b = signed'({2'b0, mr0_r});
      end
      ST_T1: begin
        fsum  = 33'(qx0_r) + 33'(qx1_r) + {1'b0, qy1_r, 1'b0};
        mul_a = signed'({1'b0, fsum});
        mul_b = signed'({2'b0, mr1_r});
      end
      ST_ER0: begin
        mul_a = signed'({18'b0, cell_r.er0});
        mul_b = signed'({3'b0, 16'hFFFF - cell_r.beta});
      end
      ST_ER1: begin
        mul_a = signed'({18'b0, cell_r.eri});
        mul_b = signed'({3'b0, cell_r.beta});
      end
      ST_MLO: begin
        mul_a = signed'({2'b0, x_r[31:0]});
        mul_b = signed'({1'b0, b_r});
      end
      ST_MHI: begin
        mul_a = signed'({2'b0, x_r[63:32]});
        mul_b = signed'({1'b0, b_r});
      end
      ST_MTOP: begin
        mul_a = signed'({30'b0, xt_r});
        mul_b = signed'({1'b0, b_r});
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    lval = (36'(iv0) <<< 16) + prod[35:0];
    lmag = lval[35] ? (~lval + 36'd1) : lval;
    lsum = lmag + 36'd32768;
    mval = lsum[32:16];
    nq   = 33'(n_r) + 33'(n_r[31:16]) + 33'd1;
  end

  // rounding shift of the long product
  always_comb begin
    rsum   = acc_r;
    rshift = acc_r;
    case (mop_r)
      MOP_PI: begin
        rsum   = acc_r + (84'd1 << 25);
        rshift = rsum >> 26;
      end
      MOP_W: begin
        rshift = acc_r;
      end
      MOP_H: begin
        if (geometry_mode) begin
          rsum   = acc_r + (84'd1 << 15);
          rshift = rsum >> 16;
        end else begin
          rsum   = acc_r + (84'd1 << 16);
          rshift = rsum >> 17;
        end
      end
      MOP_ER: begin
        rsum   = acc_r + (84'd1 << 7);
        rshift = rsum >> 8;
      end
      default: begin
      end
    endcase
  end

  assign esum     = {1'b0, energy_r} + x_r;
  assign out_free = !ovalid_r || out_pop;
  assign fq_pop   = (state_r == ST_IDLE) && !fq_stat.empty;

  always_comb begin
    state_nxt  = state_r;
    mop_nxt    = mop_r;
    cell_nxt   = cell_r;
    mx0_nxt    = mx0_r;
    mx1_nxt    = mx1_r;
    my0_nxt    = my0_r;
    my1_nxt    = my1_r;
    mr0_nxt    = mr0_r;
    mr1_nxt    = mr1_r;
    qx0_nxt    = qx0_r;
    qx1_nxt    = qx1_r;
    qy0_nxt    = qy0_r;
    qy1_nxt    = qy1_r;
    x_nxt      = x_r;
    xt_nxt     = xt_r;
    b_nxt      = b_r;
    acc_nxt    = acc_r;
    n_nxt      = n_r;
    clip_nxt   = clip_r;
    energy_nxt = energy_r;
    ovf_nxt    = ovf_r;
    ovalid_nxt = ovalid_r && !out_pop;
    oen_nxt    = oen_r;
    osat_nxt   = osat_r;
    case (state_r)
      ST_IDLE: begin
        if (!fq_stat.empty) begin
          cell_nxt  = fq_data;
          clip_nxt  = 1'b0;
          state_nxt = ST_EX0;
        end
      end
      ST_EX0: begin
        mx0_nxt   = mval;
        state_nxt = ST_EX1;
      end
      ST_EX1: begin
        mx1_nxt   = mval;
        state_nxt = ST_EY0;
      end
      ST_EY0: begin
        my0_nxt   = mval;
        state_nxt = ST_EY1;
      end
      ST_EY1: begin
        my1_nxt   = mval;
        state_nxt = geometry_mode ? ST_R0 : ST_SQX0;
      end
      ST_R0: begin
        mr0_nxt   = mval;
        state_nxt = ST_R1;
      end
      ST_R1: begin
        mr1_nxt   = mval;
        state_nxt = ST_SQX0;
      end
      ST_SQX0: begin
        qx0_nxt   = prod[30:0];
        state_nxt = ST_SQX1;
      end
      ST_SQX1: begin
        qx1_nxt   = prod[30:0];
        state_nxt = ST_SQY0;
      end
      ST_SQY0: begin
        qy0_nxt   = prod[30:0];
        state_nxt = ST_SQY1;
      end
      ST_SQY1: begin
        qy1_nxt   = prod[30:0];
        state_nxt = geometry_mode ? ST_T0 : ST_SUM;
      end
      ST_SUM: begin
        x_nxt     = 64'(qx0_r) + 64'(qx1_r) + 64'(qy0_r) + 64'(qy1_r);
        b_nxt     = {2'b0, cell_r.cell_width};
        mop_nxt   = MOP_W;
        state_nxt = ST_MLO;
      end
      ST_T0: begin
        x_nxt     = 64'(prod[49:0]);
        state_nxt = ST_T1;
      end
      ST_T1: begin
        x_nxt     = x_r + 64'(prod[49:0]);
        b_nxt     = fequ_pkg::PI_Q16;
        mop_nxt   = MOP_PI;
        state_nxt = ST_MLO;
      end
      ST_MLO: begin
        acc_nxt   = 84'(prod[49:0]);
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        acc_nxt   = acc_r + {2'b0, prod[49:0], 32'b0};
        state_nxt = ((mop_r == MOP_H) && geometry_mode) ? ST_MTOP : ST_MRND;
      end
      ST_MTOP: begin
        acc_nxt   = acc_r + {prod[19:0], 64'b0};
        state_nxt = ST_MRND;
      end
      ST_MRND: begin
        xt_nxt = '0;
        if (mop_r == MOP_W) begin
          // width product stays exact, height step rounds once
          x_nxt  = rshift[63:0];
          xt_nxt = rshift[67:64];
        end else if (rshift[83:63] != '0) begin
          x_nxt    = {1'b0, fequ_pkg::ENERGY_MAX};
          clip_nxt = 1'b1;
        end else begin
          x_nxt = rshift[63:0];
        end
        state_nxt = ST_MLO;
        case (mop_r)
          MOP_PI: begin
            mop_nxt = MOP_W;
            b_nxt   = {2'b0, cell_r.cell_width};
          end
          MOP_W: begin
            mop_nxt = MOP_H;
            b_nxt   = {2'b0, cell_r.cell_height};
          end
          MOP_H: begin
            state_nxt = weight_by_permittivity ? ST_ER0 : ST_ACC;
          end
          default: begin
            state_nxt = ST_ACC;
          end
        endcase
      end
      ST_ER0: begin
        n_nxt     = prod[31:0] + 32'd32767;
        state_nxt = ST_ER1;
      end
      ST_ER1: begin
        n_nxt     = n_r + prod[31:0];
        state_nxt = ST_ER2;
      end
      ST_ER2: begin
        b_nxt     = {2'b0, nq[31:16]};
        mop_nxt   = MOP_ER;
        state_nxt = ST_MLO;
      end
      ST_ACC: begin
        if (!cell_r.last || out_free) begin
          if (esum[63]) begin
            energy_nxt = fequ_pkg::ENERGY_MAX;
            ovf_nxt    = 1'b1;
          end else begin
            energy_nxt = esum[62:0];
            ovf_nxt    = ovf_r || clip_r;
          end
          if (cell_r.last) begin
            oen_nxt    = esum[63] ? fequ_pkg::ENERGY_MAX : esum[62:0];
            osat_nxt   = esum[63] || ovf_r || clip_r;
            ovalid_nxt = 1'b1;
            energy_nxt = '0;
            ovf_nxt    = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mop_r  <= mop_nxt;
    cell_r <= cell_nxt;
    mx0_r  <= mx0_nxt;
    mx1_r  <= mx1_nxt;
    my0_r  <= my0_nxt;
    my1_r  <= my1_nxt;
    mr0_r  <= mr0_nxt;
    mr1_r  <= mr1_nxt;
    qx0_r  <= qx0_nxt;
    qx1_r  <= qx1_nxt;
    qy0_r  <= qy0_nxt;
    qy1_r  <= qy1_nxt;
    x_r    <= x_nxt;
    xt_r   <= xt_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    n_r    <= n_nxt;
    clip_r <= clip_nxt;
    oen_r  <= oen_nxt;
    osat_r <= osat_nxt;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      energy_r <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      energy_r <= energy_nxt;
      ovf_r    <= ovf_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_empty     = !ovalid_r;
  assign out_energy    = oen_r;
  assign out_saturated = osat_r;

endmodule

// ----- design/field_energy_quadrature_accumulator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// field_energy_quadrature_accumulator_unit
// Two-point Gauss-Legendre cell energy accumulator with permittivity table.
//
//   channel  | handshake         | payload
//   ---------+-------------------+-------------------------------------------
//   input    | in_push / in_full | command, table value, index, cell fields
//   result   | out_pop / out_empty | energy total, saturated flag
//   config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// table loads are written on acceptance; the back end runs one shared multiplier
// and works longer per cylindrical cell than per planar cell, longer still when
// weighting by permittivity
// a 4-entry queue lets loads and cells keep arriving while the back end works
// synchronous active-low reset clears sums, flags and queues; table not cleared
// a last cell waits in the back end while the result register is occupied
// ----------------------------------------------------------------------------
module field_energy_quadrature_accumulator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_command,
  input  logic [15:0]        in_table_value,
  input  logic [7:0]         in_er_index,
  input  logic [15:0]        in_beta,
  input  logic signed [15:0] in_ex_near,
  input  logic signed [15:0] in_ex_far,
  input  logic signed [15:0] in_ey_near,
  input  logic signed [15:0] in_ey_far,
  input  logic [15:0]        in_cell_width,
  input  logic [15:0]        in_cell_height,
  input  logic signed [15:0] in_radius_start,
  input  logic               in_last,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [62:0]        out_energy,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic               cfg_data
);

  logic                geometry_r, geometry_nxt;
  logic                weight_r, weight_nxt;
  logic                fq_push, fq_pop;
  fequ_pkg::cell_t     fq_wdata, fq_rdata;
  fequ_pkg::fq_stat_t  fq_stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    geometry_nxt = geometry_r;
    weight_nxt   = weight_r;
    if (cfg_valid) begin
      case (cfg_index)
        fequ_pkg::CFG_GEOMETRY: geometry_nxt = cfg_data;
        fequ_pkg::CFG_WEIGHT:   weight_nxt   = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geometry_r <= 1'b0;
      weight_r   <= 1'b0;
    end else begin
      geometry_r <= geometry_nxt;
      weight_r   <= weight_nxt;
    end
  end

  fequ_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_table_value (in_table_value),
    .in_er_index    (in_er_index),
    .in_beta        (in_beta),
    .in_ex_near     (in_ex_near),
    .in_ex_far      (in_ex_far),
    .in_ey_near     (in_ey_near),
    .in_ey_far      (in_ey_far),
    .in_cell_width  (in_cell_width),
    .in_cell_height (in_cell_height),
    .in_radius_start(in_radius_start),
    .in_last        (in_last),
    .fq_stat        (fq_stat),
    .fq_push        (fq_push),
    .fq_data        (fq_wdata)
  );

  fequ_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push_i(fq_push),
    .data_i(fq_wdata),
    .pop_i (fq_pop),
    .data_o(fq_rdata),
    .stat_o(fq_stat)
  );

  fequ_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .geometry_mode         (geometry_r),
    .weight_by_permittivity(weight_r),
    .fq_stat               (fq_stat),
    .fq_data               (fq_rdata),
    .fq_pop                (fq_pop),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_energy            (out_energy),
    .out_saturated         (out_saturated)
  );

endmodule
